/* hw/rtl/rfm_pkg.sv */
`default_nettype none

package rfm_pkg;

	// Configuration port geometry.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 14;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_MIRROR_H   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIRROR_V   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PIXEL_SIZE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PACKING    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_BYTES = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_COUNT = 3'd5;

	// Packing codes.
	localparam logic [1:0] PACK_GENERIC    = 2'd0;
	localparam logic [1:0] PACK_LUMA_FIRST = 2'd1;
	localparam logic [1:0] PACK_CHROMA_FST = 2'd2;

	// Field widths.
	localparam int LB_W   = 14;           // line bytes and column
	localparam int LC_W   = 11;           // line count and row
	localparam int UNIT_W = 4;            // pixel or macropixel size
	localparam int BIP_W  = 3;            // byte index inside a pixel
	localparam int POS_W  = LB_W + LC_W;  // linear frame position

	// Remainder unit: one dividend bit per cycle.
	localparam int DIV_STEPS = LB_W;
	localparam int DIV_CNT_W = 4;

	// Result queue.
	localparam int OUT_DEPTH = 8;
	localparam int OUT_PTR_W = 3;
	localparam int OUT_CNT_W = 4;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [UNIT_W-1:0] rem;
	} rfm_div_status_t;

	typedef struct packed {
		logic             wr_en;
		logic             rd_en;
		logic             rd_zero;
		logic             rd_last;
		logic [7:0]       wdata;
		logic [POS_W-1:0] addr;
	} rfm_mem_req_t;

	typedef struct packed {
		logic       valid;
		logic       last;
		logic [7:0] data;
	} rfm_mem_rsp_t;

endpackage

`default_nettype wire

/* hw/rtl/raster_frame_mirror_core.sv */
`default_nettype none

// Raster frame mirror.
// Source bytes of one packed frame enter in raster order as requests with mode 0;
// each is stored at its mirrored position (line order reversed for a vertical
// flip, pixel or 4:2:2 macropixel order reversed for a horizontal flip, with the
// luma bytes of a macropixel swapped). Requests with mode 1 read the store back
// in raster order and return one byte with frame_end set on the last byte.
// Requests are taken one a cycle on the input channel unless held off as below.
// A read request returns its byte through a four-stage address pipeline (wrap,
// column mirror, row multiply, store port) and an eight-entry result queue.
// A write request produces nothing on the output.
// The result queue is guarded by credits: when eight read requests are pending,
// read requests stall until the receiver takes results; write requests still
// flow. Every configuration write restarts the remainder units that find the
// part of a line that holds whole pixels and the byte index inside a pixel;
// input is held off until they finish. After reset the same computation runs
// once before the first request is taken. The frame store itself is not cleared.
module raster_frame_mirror_core
	import rfm_pkg::*;
#(
	parameter int FRAME_BYTES    = 1048576,
	parameter int MAX_LINE_BYTES = 8192,
	parameter int MAX_LINES      = 1024
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic                  mode,
	input  wire logic [7:0]            pixel_byte,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [7:0]                 out_byte,
	output logic                       frame_end,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	// Configuration registers.
	logic              mirror_h_q;
	logic              mirror_v_q;
	logic [3:0]        pixel_size_q;
	logic [1:0]        packing_q;
	logic [LB_W-1:0]   line_bytes_q;
	logic [LC_W-1:0]   line_count_q;

	// Values actually used after the out-of-range cases are folded in.
	logic [LB_W-1:0]   len_eff;
	logic [LC_W-1:0]   lines_eff;
	logic [UNIT_W-1:0] unit;
	logic [LB_W-1:0]   whole;
	logic [POS_W-1:0]  total_q;

	// Write and read positions.
	logic [LB_W-1:0]   col_q;
	logic [LC_W-1:0]   row_q;
	logic [BIP_W-1:0]  bip_q;
	logic [POS_W-1:0]  rd_addr_q;

	// Control.
	logic                 start_q;
	logic                 busy;
	logic [OUT_CNT_W-1:0] pending_q;
	logic                 in_fire;
	logic                 out_fire;
	logic                 cfg_fire;
	logic                 wr_fire;
	logic                 rd_fire;

	rfm_div_status_t   len_st;
	rfm_div_status_t   col_st;

	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;
	assign out_fire  = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mirror_h_q   <= 1'b1;
			mirror_v_q   <= 1'b0;
			pixel_size_q <= 4'd1;
			packing_q    <= PACK_GENERIC;
			line_bytes_q <= LB_W'(8192);
			line_count_q <= LC_W'(128);
		end else if (cfg_fire) begin
			case (cfg_index)
				REG_MIRROR_H:   mirror_h_q   <= cfg_data[0];
				REG_MIRROR_V:   mirror_v_q   <= cfg_data[0];
				REG_PIXEL_SIZE: pixel_size_q <= cfg_data[3:0];
				REG_PACKING:    packing_q    <= cfg_data[1:0];
				REG_LINE_BYTES: line_bytes_q <= cfg_data[LB_W-1:0];
				REG_LINE_COUNT: line_count_q <= cfg_data[LC_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// A zero size counts as one; sizes above the supported maximum saturate.
	always_comb begin
		if (line_bytes_q == '0) begin
			len_eff = LB_W'(1);
		end else if (32'(line_bytes_q) > 32'(MAX_LINE_BYTES)) begin
			len_eff = LB_W'(MAX_LINE_BYTES);
		end else begin
			len_eff = line_bytes_q;
		end

		if (line_count_q == '0) begin
			lines_eff = LC_W'(1);
		end else if (32'(line_count_q) > 32'(MAX_LINES)) begin
			lines_eff = LC_W'(MAX_LINES);
		end else begin
			lines_eff = line_count_q;
		end

		// Both 4:2:2 packings work on four-byte macropixels; an unknown
		// packing code behaves like generic pixels.
		if (packing_q == PACK_LUMA_FIRST || packing_q == PACK_CHROMA_FST) begin
			unit = UNIT_W'(4);
		end else if (pixel_size_q == '0) begin
			unit = UNIT_W'(1);
		end else if (pixel_size_q > 4'd8) begin
			unit = UNIT_W'(8);
		end else begin
			unit = pixel_size_q;
		end
	end

	// The frame size is a product of configuration values only, so it is
	// refreshed every cycle and is settled long before input is taken again.
	always_ff @(posedge clk) begin
		total_q <= POS_W'({{(POS_W-LC_W){1'b0}}, lines_eff} * {{(POS_W-LB_W){1'b0}}, len_eff});
	end

	// Remainders of the line length and of the current column by the pixel size.
	// The first gives the end of the whole-pixel part of a line; the second
	// re-derives the byte index inside a pixel after the pixel size changed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 1'b1;
		end else begin
			start_q <= cfg_fire;
		end
	end

	rfm_rem_unit u_len_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start_q),
		.dividend (len_eff),
		.divisor  (unit),
		.status   (len_st)
	);

	rfm_rem_unit u_col_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start_q),
		.dividend (col_q),
		.divisor  (unit),
		.status   (col_st)
	);

	assign whole = len_eff - LB_W'(len_st.rem);
	assign busy  = start_q || len_st.busy || len_st.done || col_st.busy || col_st.done;

	// Read requests need a free slot in the result queue; write requests never
	// produce a result and only wait for the remainder unit.
	assign in_ready = !busy && (!mode || (pending_q != OUT_CNT_W'(OUT_DEPTH)));
	assign in_fire  = in_valid && in_ready;
	assign wr_fire  = in_fire && !mode;
	assign rd_fire  = in_fire && mode;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (rd_fire && !out_fire) begin
			pending_q <= pending_q + 1'b1;
		end else if (!rd_fire && out_fire) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	// Stage 0: write position, with the wrap that a register change can leave
	// pending, and the read position with its wrap at the frame end.
	logic [LB_W-1:0]   col_w;
	logic [LC_W:0]     row_pre;
	logic [LC_W-1:0]   row_w;
	logic [BIP_W-1:0]  bip_w;
	logic [LB_W:0]     col_inc;
	logic [LC_W:0]     row_inc;
	logic [LC_W-1:0]   row_next;
	logic [LC_W-1:0]   drow;
	logic [BIP_W:0]    bip_inc;
	logic [POS_W-1:0]  rd_cur;
	logic              rd_last;

	always_comb begin
		if (col_q >= len_eff) begin
			col_w   = '0;
			bip_w   = '0;
			row_pre = {1'b0, row_q} + 1'b1;
		end else begin
			col_w   = col_q;
			bip_w   = bip_q;
			row_pre = {1'b0, row_q};
		end
		row_w    = (row_pre >= {1'b0, lines_eff}) ? '0 : row_pre[LC_W-1:0];
		drow     = mirror_v_q ? (lines_eff - 1'b1 - row_w) : row_w;

		col_inc  = {1'b0, col_w} + 1'b1;
		bip_inc  = {1'b0, bip_w} + 1'b1;
		row_inc  = {1'b0, row_w} + 1'b1;
		row_next = (row_inc >= {1'b0, lines_eff}) ? '0 : row_inc[LC_W-1:0];

		rd_cur   = (rd_addr_q >= total_q) ? '0 : rd_addr_q;
		rd_last  = (POS_W'(rd_cur + 1'b1) == total_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			bip_q     <= '0;
			rd_addr_q <= '0;
		end else begin
			if (col_st.done) begin
				bip_q <= col_st.rem[BIP_W-1:0];
			end
			if (wr_fire) begin
				if (col_inc >= {1'b0, len_eff}) begin
					col_q <= '0;
					bip_q <= '0;
					row_q <= row_next;
				end else begin
					col_q <= col_inc[LB_W-1:0];
					row_q <= row_w;
					bip_q <= (bip_inc == {1'b0, unit}) ? '0 : bip_inc[BIP_W-1:0];
				end
			end
			if (rd_fire) begin
				rd_addr_q <= rd_last ? '0 : POS_W'(rd_cur + 1'b1);
			end
		end
	end

	// Stage 1 registers.
	logic             valid_s1;
	logic             mode_s1;
	logic [7:0]       data_s1;
	logic [LC_W-1:0]  drow_s1;
	logic [LB_W-1:0]  col_s1;
	logic [BIP_W-1:0] bip_s1;
	logic [POS_W-1:0] rd_addr_s1;
	logic             last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_fire;
		end
	end

	always_ff @(posedge clk) begin
		mode_s1    <= mode;
		data_s1    <= pixel_byte;
		drow_s1    <= drow;
		col_s1     <= col_w;
		bip_s1     <= bip_w;
		rd_addr_s1 <= rd_cur;
		last_s1    <= rd_last;
	end

	// Stage 1 logic: mirrored column. Whole pixels reverse their order inside
	// the whole-pixel part of the line; a trailing partial pixel stays put.
	// In the 4:2:2 packings the two luma bytes trade places.
	logic [LB_W-1:0]  pix_start;
	logic [BIP_W-1:0] bip_sw;
	logic [LB_W-1:0]  dcol;

	always_comb begin
		pix_start = col_s1 - LB_W'(bip_s1);
		bip_sw    = bip_s1;
		if (packing_q == PACK_LUMA_FIRST && !bip_s1[0]) begin
			bip_sw = bip_s1 ^ BIP_W'(2);
		end else if (packing_q == PACK_CHROMA_FST && bip_s1[0]) begin
			bip_sw = bip_s1 ^ BIP_W'(2);
		end
		if (!mirror_h_q || col_s1 >= whole) begin
			dcol = col_s1;
		end else begin
			dcol = whole - LB_W'(unit) - pix_start + LB_W'(bip_sw);
		end
	end

	// Stage 2 registers.
	logic             valid_s2;
	logic             mode_s2;
	logic [7:0]       data_s2;
	logic [LC_W-1:0]  drow_s2;
	logic [LB_W-1:0]  dcol_s2;
	logic [POS_W-1:0] rd_addr_s2;
	logic             last_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		mode_s2    <= mode_s1;
		data_s2    <= data_s1;
		drow_s2    <= drow_s1;
		dcol_s2    <= dcol;
		rd_addr_s2 <= rd_addr_s1;
		last_s2    <= last_s1;
	end

	// Stage 2 logic: linear destination of a write is row times line length
	// plus column; a read already carries its linear position.
	logic [POS_W-1:0] wr_addr;

	assign wr_addr = POS_W'({{(POS_W-LC_W){1'b0}}, drow_s2}
		* {{(POS_W-LB_W){1'b0}}, len_eff}) + POS_W'(dcol_s2);

	// Stage 3 registers: the store request.
	logic             valid_s3;
	logic             mode_s3;
	logic [7:0]       data_s3;
	logic [POS_W-1:0] addr_s3;
	logic             last_s3;
	logic             in_store;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		mode_s3 <= mode_s2;
		data_s3 <= data_s2;
		addr_s3 <= mode_s2 ? rd_addr_s2 : wr_addr;
		last_s3 <= last_s2;
	end

	// Writes past the end of the store are dropped; reads there return zero.
	// Requests reach the single store port in acceptance order, so a read
	// always sees every earlier write.
	rfm_mem_req_t mem_req;
	rfm_mem_rsp_t mem_rsp;

	assign in_store         = (32'(addr_s3) < 32'(FRAME_BYTES));
	assign mem_req.wr_en    = valid_s3 && !mode_s3 && in_store;
	assign mem_req.rd_en    = valid_s3 && mode_s3;
	assign mem_req.rd_zero  = !in_store;
	assign mem_req.rd_last  = last_s3;
	assign mem_req.wdata    = data_s3;
	assign mem_req.addr     = addr_s3;

	rfm_frame_mem #(
		.FRAME_BYTES (FRAME_BYTES)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mem_req),
		.rsp    (mem_rsp)
	);

	rfm_out_fifo u_results (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mem_rsp),
		.pop    (out_ready),
		.valid  (out_valid),
		.data   (out_byte),
		.last   (frame_end)
	);

	// Credits never exceed the queue depth.
	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= OUT_CNT_W'(OUT_DEPTH))
		else $error("pending read count exceeds result queue depth");

	// No request enters while the remainder unit is working.
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |-> !(len_st.busy || col_st.busy))
		else $error("request accepted during remainder computation");

	// A result is only offered for a read that is still pending.
	a_result_pending: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pending_q != '0))
		else $error("result present without a pending read");

	// The store is never written outside its range.
	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.wr_en |-> (32'(mem_req.addr) < 32'(FRAME_BYTES)))
		else $error("store write beyond frame size");

endmodule

`default_nettype wire

/* hw/rtl/rfm_rem_unit.sv */
`default_nettype none

// Restoring remainder of a line-sized value by a pixel size, one bit a cycle.
module rfm_rem_unit
	import rfm_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [LB_W-1:0]   dividend,
	input  wire logic [UNIT_W-1:0] divisor,
	output rfm_div_status_t        status
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [LB_W-1:0]      dvd_q;
	logic [UNIT_W-1:0]    dsr_q;
	logic [UNIT_W-1:0]    rem_q;
	logic [UNIT_W:0]      trial;

	assign trial = {rem_q, dvd_q[LB_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_STEPS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[LB_W-2:0], 1'b0};
			if (trial >= {1'b0, dsr_q}) begin
				rem_q <= UNIT_W'(trial - {1'b0, dsr_q});
			end else begin
				rem_q <= trial[UNIT_W-1:0];
			end
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign status.rem  = rem_q;

endmodule

`default_nettype wire

/* hw/rtl/rfm_frame_mem.sv */
`default_nettype none

// Single-port frame store: one write or one read a cycle, registered read data.
module rfm_frame_mem
	import rfm_pkg::*;
#(
	parameter int FRAME_BYTES = 1048576
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  rfm_mem_req_t req,
	output rfm_mem_rsp_t rsp
);

	localparam int AW = $clog2(FRAME_BYTES);

	logic [7:0]    store [FRAME_BYTES];
	logic [7:0]    rdata_q;
	logic          rvalid_q;
	logic          rzero_q;
	logic          rlast_q;
	logic [AW-1:0] idx;

	assign idx = req.addr[AW-1:0];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			store[idx] <= req.wdata;
		end
		if (req.rd_en) begin
			rdata_q <= store[idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvalid_q <= 1'b0;
			rzero_q  <= 1'b0;
			rlast_q  <= 1'b0;
		end else begin
			rvalid_q <= req.rd_en;
			rzero_q  <= req.rd_zero;
			rlast_q  <= req.rd_last;
		end
	end

	// Positions past the end of the store read as zero.
	assign rsp.valid = rvalid_q;
	assign rsp.last  = rlast_q;
	assign rsp.data  = rzero_q ? 8'd0 : rdata_q;

endmodule

`default_nettype wire

/* hw/rtl/rfm_out_fifo.sv */
`default_nettype none

// Result queue between the frame store and the output channel.
module rfm_out_fifo
	import rfm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  rfm_mem_rsp_t     push,
	input  wire logic        pop,
	output logic             valid,
	output logic [7:0]       data,
	output logic             last
);

	logic [8:0]           slot_q [OUT_DEPTH];
	logic [OUT_PTR_W-1:0] wr_ptr_q;
	logic [OUT_PTR_W-1:0] rd_ptr_q;
	logic [OUT_CNT_W-1:0] count_q;
	logic                 do_pop;

	assign do_pop = pop && (count_q != '0);

	always_ff @(posedge clk) begin
		if (push.valid) begin
			slot_q[wr_ptr_q] <= {push.last, push.data};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push.valid && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push.valid && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign valid = (count_q != '0);
	assign last  = slot_q[rd_ptr_q][8];
	assign data  = slot_q[rd_ptr_q][7:0];

endmodule

`default_nettype wire
